/* hw/rtl/xalu_pkg.sv */
`default_nettype none
package xalu_pkg;
   localparam int DataWidth = 32;

   typedef enum logic [3:0] {
      KIND_ADD = 4'd0, KIND_SUB = 4'd1, KIND_CMP = 4'd2, KIND_INC = 4'd3,
      KIND_DEC = 4'd4, KIND_NEG = 4'd5, KIND_ADC = 4'd6, KIND_SBB = 4'd7,
      KIND_MUL = 4'd8, KIND_IMULW = 4'd9, KIND_IMULL = 4'd10,
      KIND_DIV = 4'd11, KIND_IDIV = 4'd12, KIND_NOP = 4'd15
   } kind_type;

   typedef enum logic [1:0] {
      SIZE_BYTE = 2'd0, SIZE_WORD = 2'd1, SIZE_DWORD = 2'd2, SIZE_DWORD3 = 2'd3
   } size_type;

   // classified work item passed from front to back
   typedef struct packed {
      kind_type kind;
      size_type size;
      logic [31:0] a;       // masked first operand
      logic [31:0] b;       // masked second operand
      logic [31:0] mult;    // masked multiplier
      logic [63:0] dividend;
   } op_type;

   localparam int QueueDepth = 2;
endpackage
`default_nettype wire

/* hw/rtl/xalu_front.sv */
`default_nettype none
module xalu_front (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [3:0] req_kind,
   input  wire logic [1:0] req_size,
   input  wire logic [31:0] req_first_operand,
   input  wire logic [31:0] req_second_operand,
   input  wire logic [31:0] req_acc_low,
   input  wire logic [31:0] req_acc_high,
   output logic q_valid,
   input  wire logic q_ready,
   output xalu_pkg::op_type q_op
);
   import xalu_pkg::*;

   op_type slot_ff [QueueDepth];
   logic [1:0] cnt_ff, cnt_in;
   logic rd_ff, rd_in, wr_ff, wr_in;
   logic [31:0] mask;
   op_type cls;
   logic push, pop;

   always_comb begin
      case (req_size)
         SIZE_BYTE: mask = 32'h0000_00FF;
         SIZE_WORD: mask = 32'h0000_FFFF;
         default:   mask = 32'hFFFF_FFFF;
      endcase
      cls.size = (req_size == SIZE_DWORD3) ? SIZE_DWORD : size_type'(req_size);
      cls.kind = (req_kind > 4'd12) ? KIND_NOP : kind_type'(req_kind);
      cls.a = req_first_operand & mask;
      cls.b = req_second_operand & mask;
      cls.mult = req_acc_low & mask;
      case (req_size)
         SIZE_BYTE: cls.dividend = {48'd0, req_acc_low[15:0]};
         SIZE_WORD: cls.dividend = {32'd0, req_acc_high[15:0], req_acc_low[15:0]};
         default:   cls.dividend = {req_acc_high, req_acc_low};
      endcase
   end

   assign req_ready = (cnt_ff != 2'(QueueDepth));
   assign push = req_valid && req_ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign pop = q_valid && q_ready;
   assign q_op = slot_ff[rd_ff];
   assign cnt_in = cnt_ff + 2'(push) - 2'(pop);
   assign rd_in = rd_ff ^ pop;
   assign wr_in = wr_ff ^ push;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
      end
      if (push) slot_ff[wr_ff] <= cls;
   end
endmodule
`default_nettype wire

/* hw/rtl/xalu_back.sv */
`default_nettype none
module xalu_back (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic q_valid,
   output logic q_ready,
   input  wire xalu_pkg::op_type q_op,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [31:0] rsp_result_low,
   output logic [31:0] rsp_result_high,
   output logic rsp_writes_back,
   output logic rsp_carry_out,
   output logic rsp_zero_out,
   output logic rsp_sign_out,
   output logic rsp_overflow_out,
   output logic rsp_divide_error
);
   import xalu_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001, ST_MUL = 5'b00010, ST_DIV = 5'b00100,
      ST_DFIN = 5'b01000, ST_OUT = 5'b10000
   } state_type;

   state_type st_ff, st_in;
   op_type op_ff;
   logic cf_ff, zf_ff, sf_ff, of_ff;
   logic [31:0] lo_ff, hi_ff;
   logic wb_ff, derr_ff;
   logic [63:0] prod_ff;
   logic [63:0] dq_ff;     // dividend magnitude shifting into quotient
   logic [32:0] rem_ff;
   logic [31:0] dvs_ff;
   logic [5:0] cnt_ff;
   logic dneg_ff, sneg_ff;

   logic [5:0] w, dw;
   logic [31:0] m;
   always_comb begin
      case (op_ff.size)
         SIZE_BYTE: begin w = 6'd8;  m = 32'hFF; end
         SIZE_WORD: begin w = 6'd16; m = 32'hFFFF; end
         default:   begin w = 6'd32; m = 32'hFFFF_FFFF; end
      endcase
      dw = {w[4:0], 1'b0};
   end

   function automatic logic [31:0] sext(input logic [31:0] v, input size_type s);
      case (s)
         SIZE_BYTE: sext = {{24{v[7]}}, v[7:0]};
         SIZE_WORD: sext = {{16{v[15]}}, v[15:0]};
         default:   sext = v;
      endcase
   endfunction

   function automatic logic msb(input logic [31:0] v, input size_type s);
      case (s)
         SIZE_BYTE: msb = v[7];
         SIZE_WORD: msb = v[15];
         default:   msb = v[31];
      endcase
   endfunction

   // add/sub unit on the queue head
   logic [31:0] qm, x, y, res;
   logic [32:0] full;
   logic cin, is_sub, cout, keep_cf, nz, ncf, nof;
   always_comb begin
      case (q_op.size)
         SIZE_BYTE: qm = 32'hFF;
         SIZE_WORD: qm = 32'hFFFF;
         default:   qm = 32'hFFFF_FFFF;
      endcase
      x = q_op.a; y = q_op.b; cin = 1'b0; is_sub = 1'b0; keep_cf = 1'b0;
      case (q_op.kind)
         KIND_SUB, KIND_CMP: is_sub = 1'b1;
         KIND_INC: begin y = 32'd1; keep_cf = 1'b1; end
         KIND_DEC: begin y = 32'd1; is_sub = 1'b1; keep_cf = 1'b1; end
         KIND_NEG: begin x = 32'd0; y = q_op.a; is_sub = 1'b1; end
         KIND_ADC: cin = cf_ff;
         KIND_SBB: begin cin = cf_ff; is_sub = 1'b1; end
         default: ;
      endcase
      // a - b - c = a + ~b + !c at width
      full = is_sub ? ({1'b0, x} + {1'b0, ~y & qm} + 33'(!cin))
                    : ({1'b0, x} + {1'b0, y} + 33'(cin));
      res = full[31:0] & qm;
      case (q_op.size)
         SIZE_BYTE: cout = full[8];
         SIZE_WORD: cout = full[16];
         default:   cout = full[32];
      endcase
      if (is_sub) cout = !cout;
      nz = (res == 32'd0);
      nof = is_sub ? msb((x ^ y) & (x ^ res), q_op.size)
                   : msb(~(x ^ y) & (x ^ res), q_op.size);
      ncf = keep_cf ? cf_ff : cout;
      if (q_op.kind == KIND_NEG) ncf = (q_op.a != 32'd0);
   end

   // restoring divide step
   logic [32:0] trial;
   logic [63:0] dq_sh;
   logic [32:0] rem_sh;
   always_comb begin
      rem_sh = {rem_ff[31:0], dq_ff[6'(dw - 6'd1)]};
      trial = rem_sh - {1'b0, dvs_ff};
      dq_sh = dq_ff << 1;
   end

   // final divide fixup; a doubleword divide keeps all 64 quotient bits
   logic [63:0] qmag;
   logic fits;
   logic [31:0] half;
   always_comb begin
      qmag = (dw == 6'd0) ? dq_ff : (dq_ff & ((64'd1 << dw) - 64'd1));
      half = 32'd1 << (w - 6'd1);
      if (op_ff.kind == KIND_DIV) fits = (qmag <= {32'd0, m});
      else if (dneg_ff != sneg_ff) fits = (qmag <= {32'd0, half});
      else fits = (qmag < {32'd0, half});
   end

   logic [63:0] sp;
   logic [63:0] dmag_in;
   logic dneg_in, sneg_in;
   logic [31:0] smag_in;
   logic [31:0] ma, mb;
   logic signed [32:0] sa, sb;
   logic signed [65:0] sprod;
   always_comb begin
      dneg_in = 1'b0; sneg_in = 1'b0;
      dmag_in = q_op.dividend; smag_in = q_op.a;
      if (q_op.kind == KIND_IDIV) begin
         case (q_op.size)
            SIZE_BYTE: dneg_in = q_op.dividend[15];
            SIZE_WORD: dneg_in = q_op.dividend[31];
            default:   dneg_in = q_op.dividend[63];
         endcase
         sneg_in = msb(q_op.a, q_op.size);
         if (dneg_in) dmag_in = (64'd0 - q_op.dividend) & ((64'd1 << {qm == 32'hFF ? 6'd16 :
            qm == 32'hFFFF ? 6'd32 : 6'd0}) - 64'd1 | {64{qm == 32'hFFFF_FFFF}});
         if (sneg_in) smag_in = (32'd0 - q_op.a) & qm;
      end
      // one 33x33 signed multiplier: zero-extend for mul, sign-extend for imul
      ma = (op_ff.kind == KIND_MUL) ? op_ff.a : sext(op_ff.a, op_ff.size);
      mb = (op_ff.kind == KIND_MUL) ? op_ff.mult
         : (op_ff.kind == KIND_IMULW) ? sext(op_ff.mult, op_ff.size)
         : sext(op_ff.b, op_ff.size);
      sa = $signed({(op_ff.kind != KIND_MUL) && ma[31], ma});
      sb = $signed({(op_ff.kind != KIND_MUL) && mb[31], mb});
      sprod = sa * sb;
      sp = sprod[63:0];
   end

   assign q_ready = (st_ff == ST_IDLE);
   assign rsp_valid = (st_ff == ST_OUT);
   assign rsp_result_low = lo_ff;
   assign rsp_result_high = hi_ff;
   assign rsp_writes_back = wb_ff;
   assign rsp_carry_out = cf_ff;
   assign rsp_zero_out = zf_ff;
   assign rsp_sign_out = sf_ff;
   assign rsp_overflow_out = of_ff;
   assign rsp_divide_error = derr_ff;

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (q_valid) begin
            case (q_op.kind)
               KIND_MUL, KIND_IMULW, KIND_IMULL: st_in = ST_MUL;
               KIND_DIV, KIND_IDIV: st_in = (smag_in == 32'd0) ? ST_OUT : ST_DIV;
               default: st_in = ST_OUT;
            endcase
         end
         ST_MUL: st_in = ST_DFIN;
         ST_DIV: if (cnt_ff == 6'd1) st_in = ST_DFIN;
         ST_DFIN: st_in = ST_OUT;
         ST_OUT: if (rsp_ready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         cf_ff <= 1'b0; zf_ff <= 1'b0; sf_ff <= 1'b0; of_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (st_ff == ST_IDLE && q_valid) begin
            case (q_op.kind)
               KIND_ADD, KIND_SUB, KIND_CMP, KIND_INC, KIND_DEC, KIND_NEG,
               KIND_ADC, KIND_SBB: begin
                  cf_ff <= ncf; zf_ff <= nz; sf_ff <= msb(res, q_op.size);
                  of_ff <= nof;
               end
               default: ;
            endcase
         end
      end
      case (st_ff)
         ST_IDLE: begin
            op_ff <= q_op;
            lo_ff <= 32'd0; hi_ff <= 32'd0; derr_ff <= 1'b0;
            wb_ff <= !(q_op.kind == KIND_CMP || q_op.kind == KIND_NOP);
            case (q_op.kind)
               KIND_ADD, KIND_SUB, KIND_INC, KIND_DEC, KIND_NEG, KIND_ADC,
               KIND_SBB: lo_ff <= res;
               KIND_DIV, KIND_IDIV: if (smag_in == 32'd0) begin
                  derr_ff <= 1'b1; wb_ff <= 1'b0;
               end
               default: ;
            endcase
            dq_ff <= dmag_in; dvs_ff <= smag_in; rem_ff <= '0;
            dneg_ff <= dneg_in; sneg_ff <= sneg_in;
            cnt_ff <= {q_op.size == SIZE_BYTE ? 6'd16 : q_op.size == SIZE_WORD ? 6'd32 : 6'd0};
         end
         ST_MUL: prod_ff <= sp;
         ST_DIV: begin
            // shift one quotient bit in per cycle
            cnt_ff <= cnt_ff - 6'd1;
            if (!trial[32]) begin
               rem_ff <= trial; dq_ff <= dq_sh | 64'd1;
            end else begin
               rem_ff <= rem_sh; dq_ff <= dq_sh;
            end
         end
         ST_DFIN: begin
            if (op_ff.kind == KIND_MUL || op_ff.kind == KIND_IMULW) begin
               lo_ff <= prod_ff[31:0] & m;
               hi_ff <= 32'(prod_ff >> w) & m;
            end else if (op_ff.kind == KIND_IMULL) begin
               lo_ff <= prod_ff[31:0] & m;
            end else if (!fits) begin
               derr_ff <= 1'b1; wb_ff <= 1'b0;
            end else begin
               lo_ff <= ((dneg_ff != sneg_ff) ? (32'd0 - qmag[31:0]) : qmag[31:0]) & m;
               hi_ff <= (dneg_ff ? (32'd0 - rem_ff[31:0]) : rem_ff[31:0]) & m;
            end
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

/* hw/rtl/x86_integer_alu_flags_top.sv */
// channel | direction | handshake              | payload
// req     | in        | req_valid / req_ready  | kind, size, operands, acc_low/high
// rsp     | out       | rsp_valid / rsp_ready  | results, writes_back, flags, divide_error
// An item is registered in the queue before the back end takes it.
// Add/sub class and divide by zero go from idle straight to output; multiply passes MUL and DFIN.
// Divide: 2*width quotient steps (16, 32 or 64) in the shift-subtract loop, then DFIN and output.
// A two-entry queue decouples intake from execution; input stays open while it has room.
// Reset (synchronous) clears the flags, the queue and the back-end sequencer.
`default_nettype none
module x86_integer_alu_flags_top (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [3:0] req_kind,
   input  wire logic [1:0] req_size,
   input  wire logic [31:0] req_first_operand,
   input  wire logic [31:0] req_second_operand,
   input  wire logic [31:0] req_acc_low,
   input  wire logic [31:0] req_acc_high,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [31:0] rsp_result_low,
   output logic [31:0] rsp_result_high,
   output logic rsp_writes_back,
   output logic rsp_carry_out,
   output logic rsp_zero_out,
   output logic rsp_sign_out,
   output logic rsp_overflow_out,
   output logic rsp_divide_error
);
   import xalu_pkg::*;

   logic q_valid, q_ready;
   op_type q_op;

   // classify and hold items until the back end takes them
   xalu_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_kind, .req_size,
      .req_first_operand, .req_second_operand, .req_acc_low, .req_acc_high,
      .q_valid, .q_ready, .q_op
   );

   // execute one item at a time and hold the result until transfer
   xalu_back u_back (
      .clock, .reset, .q_valid, .q_ready, .q_op, .rsp_valid, .rsp_ready,
      .rsp_result_low, .rsp_result_high, .rsp_writes_back, .rsp_carry_out,
      .rsp_zero_out, .rsp_sign_out, .rsp_overflow_out, .rsp_divide_error
   );
endmodule
`default_nettype wire

/* tb/tb_x86_integer_alu_flags_top.sv */
`default_nettype none
module tb_x86_integer_alu_flags_top;
   timeunit 1ns;
   timeprecision 1ps;
   import xalu_pkg::*;

   // one ALU outcome, as it appears on the response channel
   typedef struct packed {
      logic [31:0] res_lo;
      logic [31:0] res_hi;
      logic        wb;
      logic        cf;
      logic        zf;
      logic        sf;
      logic        of;
      logic        derr;
   } alu_outcome_t;

   localparam int CycleLimit = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [3:0] req_kind = '0;
   logic [1:0] req_size = '0;
   logic [31:0] req_first_operand = '0;
   logic [31:0] req_second_operand = '0;
   logic [31:0] req_acc_low = '0;
   logic [31:0] req_acc_high = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [31:0] rsp_result_low;
   logic [31:0] rsp_result_high;
   logic rsp_writes_back;
   logic rsp_carry_out;
   logic rsp_zero_out;
   logic rsp_sign_out;
   logic rsp_overflow_out;
   logic rsp_divide_error;

   x86_integer_alu_flags_top DUT (.*);

   // Flag copy kept by the predictor; it advances once per accepted request.
   logic flag_c = 1'b0, flag_z = 1'b0, flag_s = 1'b0, flag_o = 1'b0;
   alu_outcome_t pending_outcomes[$];
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   bit stalls_enabled = 1'b1;

   initial begin
      forever #6 clock = ~clock;
   end

   // Count cycles and end the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s mismatch got %h want %h", $realtime, what, got, want);
      mismatches++;
   endtask

   function automatic int unsigned width_of(input logic [1:0] sz);
      return sz == SIZE_BYTE ? 8 : sz == SIZE_WORD ? 16 : 32;
   endfunction

   // Set ZF and SF from a width-masked result.
   function automatic void set_zero_sign(input logic [63:0] r, input int unsigned w);
      flag_z = (r == 0);
      flag_s = r[w-1];
   endfunction

   function automatic logic [63:0] add_at_width(input logic [63:0] a, b,
                                                input logic cin, input int unsigned w,
                                                input bit keep_cf);
      logic [63:0] m, full, r, ov;
      m = (64'd1 << w) - 1;
      full = a + b + cin;
      r = full & m;
      if (!keep_cf) flag_c = full[w];
      set_zero_sign(r, w);
      ov = ~(a ^ b) & (a ^ r);
      flag_o = ov[w-1];
      return r;
   endfunction

   function automatic logic [63:0] sub_at_width(input logic [63:0] a, b,
                                                input logic cin, input int unsigned w,
                                                input bit keep_cf);
      logic [63:0] m, r, ov;
      m = (64'd1 << w) - 1;
      r = (a - b - cin) & m;
      if (!keep_cf) flag_c = a < b + cin;
      set_zero_sign(r, w);
      ov = (a ^ b) & (a ^ r);
      flag_o = ov[w-1];
      return r;
   endfunction

   function automatic logic [63:0] sext(input logic [63:0] v, input int unsigned w);
      logic [63:0] m;
      m = (64'd1 << w) - 1;
      v &= m;
      if (v[w-1]) v |= ~m;
      return v;
   endfunction

   // Work out the outcome of one request and advance the flag copy.
   function automatic alu_outcome_t execute_alu_op(input logic [3:0] kd, input logic [1:0] sz,
                                                   input logic [31:0] fo, so, lo, hi);
      int unsigned w;
      logic [63:0] m, a, b, r_lo, r_hi, x, y, p, dividend, dmag, smag, qmag, rmag;
      logic [127:0] wide;
      logic wb, derr, dneg, sneg, fits;
      alu_outcome_t o;
      w = width_of(sz);
      m = (64'd1 << w) - 1;
      a = fo & m;
      b = so & m;
      r_lo = 0;
      r_hi = 0;
      wb = 1;
      derr = 0;
      case (kd)
         KIND_ADD: r_lo = add_at_width(a, b, 0, w, 0);
         KIND_SUB: r_lo = sub_at_width(a, b, 0, w, 0);
         KIND_CMP: begin
            void'(sub_at_width(a, b, 0, w, 0));
            wb = 0;
         end
         KIND_INC: r_lo = add_at_width(a, 1, 0, w, 1);
         KIND_DEC: r_lo = sub_at_width(a, 1, 0, w, 1);
         KIND_NEG: begin
            r_lo = sub_at_width(0, a, 0, w, 1);
            flag_c = (a != 0);
         end
         KIND_ADC: r_lo = add_at_width(a, b, flag_c, w, 0);
         KIND_SBB: r_lo = sub_at_width(a, b, flag_c, w, 0);
         KIND_MUL, KIND_IMULW: begin
            x = a;
            y = lo & m;
            if (kd == KIND_IMULW) begin
               x = sext(x, w);
               y = sext(y, w);
            end
            p = x * y;
            r_lo = p & m;
            r_hi = (p >> w) & m;
         end
         KIND_IMULL: r_lo = (sext(a, w) * sext(b, w)) & m;
         KIND_DIV, KIND_IDIV: begin
            if (w == 8) dividend = {48'd0, lo[15:0]};
            else if (w == 16) dividend = {32'd0, hi[15:0], lo[15:0]};
            else dividend = {hi, lo};
            dmag = dividend;
            smag = a;
            dneg = 0;
            sneg = 0;
            if (kd == KIND_IDIV) begin
               dneg = dividend[2*w-1];
               sneg = a[w-1];
               wide = (128'd1 << (2 * w)) - 1;
               if (dneg) dmag = (64'd0 - dividend) & wide[63:0];
               if (sneg) smag = (64'd0 - a) & m;
            end
            if (smag == 0) derr = 1;
            else begin
               qmag = dmag / smag;
               rmag = dmag % smag;
               if (kd == KIND_DIV) fits = qmag <= m;
               else if (dneg != sneg) fits = qmag <= (64'd1 << (w - 1));
               else fits = qmag < (64'd1 << (w - 1));
               if (!fits) derr = 1;
               else begin
                  r_lo = ((dneg != sneg) ? (64'd0 - qmag) : qmag) & m;
                  r_hi = (dneg ? (64'd0 - rmag) : rmag) & m;
               end
            end
         end
         default: wb = 0;
      endcase
      if (derr) begin
         r_lo = 0;
         r_hi = 0;
         wb = 0;
      end
      o.res_lo = r_lo[31:0];
      o.res_hi = r_hi[31:0];
      o.wb = wb;
      o.cf = flag_c;
      o.zf = flag_z;
      o.sf = flag_s;
      o.of = flag_o;
      o.derr = derr;
      return o;
   endfunction

   // Random idle length: mostly short, sometimes long.
   function automatic int unsigned idle_cycles();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Drive one request and hold it until the transfer happens; valid stays up
   // after the transfer so the next item can follow with no gap.
   task automatic send_op(input logic [3:0] kd, input logic [1:0] sz,
                          input logic [31:0] fo, so, lo, hi);
      int unsigned gap;
      gap = stalls_enabled ? idle_cycles() : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kd;
      req_size <= sz;
      req_first_operand <= fo;
      req_second_operand <= so;
      req_acc_low <= lo;
      req_acc_high <= hi;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // predict at the transfer edge so the queue is ahead of the response
      pending_outcomes.push_back(execute_alu_op(kd, sz, fo, so, lo, hi));
   endtask

   // Response side: toggle ready at random on falling edges.
   initial begin
      @(negedge clock);
      forever begin
         if (stalls_enabled && $urandom_range(0, 40) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(10, 50)) @(negedge clock);
         end else begin
            rsp_ready <= stalls_enabled ? ($urandom_range(0, 3) != 0) : 1'b1;
            @(negedge clock);
         end
      end
   end

   // Compare every response transfer with the oldest prediction.
   always @(posedge clock) begin
      alu_outcome_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: response with nothing pending", $realtime);
            mismatches++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_result_low !== want.res_lo)
               report_mismatch("result_low", rsp_result_low, want.res_lo);
            if (rsp_result_high !== want.res_hi)
               report_mismatch("result_high", rsp_result_high, want.res_hi);
            if (rsp_writes_back !== want.wb)
               report_mismatch("writes_back", rsp_writes_back, want.wb);
            if (rsp_carry_out !== want.cf)
               report_mismatch("carry_out", rsp_carry_out, want.cf);
            if (rsp_zero_out !== want.zf)
               report_mismatch("zero_out", rsp_zero_out, want.zf);
            if (rsp_sign_out !== want.sf)
               report_mismatch("sign_out", rsp_sign_out, want.sf);
            if (rsp_overflow_out !== want.of)
               report_mismatch("overflow_out", rsp_overflow_out, want.of);
            if (rsp_divide_error !== want.derr)
               report_mismatch("divide_error", rsp_divide_error, want.derr);
         end
      end
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000 >> (8 * $urandom_range(0, 3));
         3: return $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   // Drop valid, then wait until every predicted result has come back.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // Extremes, every operation, and the flag special cases.
   task automatic test_directed();
      send_op(KIND_ADD, SIZE_BYTE, 32'hFF, 32'h01, 0, 0);          // carry and zero
      send_op(KIND_ADC, SIZE_BYTE, 32'h7F, 32'h00, 0, 0);          // carry in overflows
      send_op(KIND_SUB, SIZE_WORD, 32'h0, 32'h1, 0, 0);            // borrow
      send_op(KIND_SBB, SIZE_WORD, 32'h8000, 32'h0, 0, 0);         // borrow in
      send_op(KIND_CMP, SIZE_DWORD, 32'h8000_0000, 32'h1, 0, 0);
      send_op(KIND_INC, SIZE_DWORD, 32'hFFFF_FFFF, 0, 0, 0);       // carry held
      send_op(KIND_DEC, SIZE_BYTE, 32'h80, 0, 0, 0);
      send_op(KIND_NEG, SIZE_BYTE, 32'h0, 0, 0, 0);                // neg of zero
      send_op(KIND_NEG, SIZE_DWORD3, 32'h8000_0000, 0, 0, 0);      // size three
      send_op(KIND_MUL, SIZE_DWORD, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0);
      send_op(KIND_IMULW, SIZE_WORD, 32'h8000, 0, 32'hFFFF, 0);
      send_op(KIND_IMULL, SIZE_BYTE, 32'h80, 32'h80, 0, 0);
      send_op(KIND_DIV, SIZE_DWORD, 32'h0, 0, 32'h1234, 0);        // divide by zero
      send_op(KIND_DIV, SIZE_BYTE, 32'h1, 0, 32'h0100, 0);         // quotient too big
      send_op(KIND_DIV, SIZE_WORD, 32'h7, 0, 32'hABCD, 32'h0003);
      send_op(KIND_IDIV, SIZE_BYTE, 32'hFF, 0, 32'hFF80, 0);       // -128 / -1 overflows
      send_op(KIND_IDIV, SIZE_BYTE, 32'h01, 0, 32'hFF80, 0);       // -128 fits
      send_op(KIND_IDIV, SIZE_WORD, 32'hFFFD, 0, 32'hFFF9, 32'hFFFF);
      send_op(KIND_IDIV, SIZE_DWORD, 32'hFFFF_FFFF, 0, 32'h0, 32'h8000_0000);
      send_op(KIND_DIV, SIZE_DWORD, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
      send_op(4'd13, SIZE_BYTE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_op(KIND_NOP, SIZE_WORD, 0, 0, 0, 0);
   endtask

   // Hold the sender until the block has returned everything.
   task automatic test_drain_pause();
      drain_results();
      send_op(KIND_ADC, SIZE_DWORD, 32'hFFFF_FFFF, 32'h0, 0, 0);
      drain_results();
   endtask

   // Random operations; divides are shaped so most quotients fit.
   task automatic test_random(input int unsigned count);
      logic [3:0] kd;
      logic [1:0] sz;
      logic [31:0] fo, so, lo, hi;
      for (int unsigned i = 0; i < count; i++) begin
         kd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15))
                                            : 4'($urandom_range(0, 12));
         sz = 2'($urandom_range(0, 3));
         fo = rand_word();
         so = rand_word();
         lo = rand_word();
         hi = rand_word();
         if ((kd == KIND_DIV || kd == KIND_IDIV) && $urandom_range(0, 3) != 0) begin
            // small high half keeps the quotient inside the width
            fo = $urandom | 32'h0100_0101;
            hi = $urandom_range(0, 1) ? $urandom_range(0, 255) : 32'hFFFF_FFFF;
            if (sz == SIZE_BYTE) lo[15:8] = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
         end
         // short stretch with no idling on either side
         stalls_enabled = !(i >= count / 2 && i < count / 2 + 60);
         send_op(kd, sz, fo, so, lo, hi);
      end
      stalls_enabled = 1'b1;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_drain_pause();
      test_random(1100);
      drain_results();
      repeat (100) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* x86_integer_alu_flags_top.f */
hw/rtl/xalu_pkg.sv
hw/rtl/xalu_front.sv
hw/rtl/xalu_back.sv
hw/rtl/x86_integer_alu_flags_top.sv
tb/tb_x86_integer_alu_flags_top.sv
